// ===== rtl/sntt_pkg.sv =====
// Shared types and constants for the strongest-network top-k table.
package sntt_pkg;

  localparam int TABLE_ENTRIES = 12;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W = 64;
  localparam int STR_W = 8;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [STR_W-1:0] strength;
    logic                    secured;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic                    entry_valid;
    logic [KEY_W-1:0]        out_key;
    logic signed [STR_W-1:0] out_strength;
    logic                    out_secured;
    logic                    out_last;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t item;
  } push_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_SORT,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/sntt_if.sv =====
// Valid/ready channel interfaces for scan reports and ranked results.
interface sntt_in_if;
  logic                               valid;
  logic                               ready;
  logic [sntt_pkg::KEY_W-1:0]         network_key;
  logic                               key_empty;
  logic signed [sntt_pkg::STR_W-1:0]  signal_strength;
  logic                               secured;
  logic                               end_of_scan;

  modport source (output valid, network_key, key_empty, signal_strength, secured,
                  end_of_scan, input ready);
  modport sink (input valid, network_key, key_empty, signal_strength, secured,
                end_of_scan, output ready);
endinterface

interface sntt_out_if;
  logic                               valid;
  logic                               ready;
  logic                               entry_valid;
  logic [sntt_pkg::KEY_W-1:0]         out_key;
  logic signed [sntt_pkg::STR_W-1:0]  out_strength;
  logic                               out_secured;
  logic                               out_last;

  modport source (output valid, entry_valid, out_key, out_strength, out_secured,
                  out_last, input ready);
  modport sink (input valid, entry_valid, out_key, out_strength, out_secured,
                out_last, output ready);
endinterface

// ===== rtl/strongest_network_topk_table.sv =====
// Top level of the strongest-network top-k table.
// Keeps up to TABLE_ENTRIES networks of one scan in a slot memory with one
// read and one write port. For a report with a key the memory is swept one
// slot a cycle for a key match and the first weakest slot, then a write-back
// step follows. A report with an empty key and no scan end needs no sweep.
// On the scan end the table is read out strongest first by selection over
// the memory: each result costs a sweep of the kept slots, and one
// empty-table result is given if nothing was kept.
// No new report is taken during a sweep or a readout; the last result may
// wait in the output register while the next report is accepted.
module strongest_network_topk_table (
  input  logic        clk,
  input  logic        rst_n,
  sntt_in_if.sink     in_ch,
  sntt_out_if.source  out_ch
);

  sntt_pkg::ram_req_t            ram_req;
  logic [sntt_pkg::SLOT_W-1:0]   ram_rdata;
  sntt_pkg::push_t               push;
  logic                          push_ready;

  sntt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .push       (push),
    .push_ready (push_ready)
  );

  sntt_ram #(
    .DEPTH (sntt_pkg::TABLE_ENTRIES),
    .WIDTH (sntt_pkg::SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  sntt_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule

// ===== rtl/sntt_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module sntt_ram #(
  parameter int DEPTH = 12,
  parameter int WIDTH = 73
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sntt_seq.sv =====
// Sequencer: key/weakest sweep, merge write-back and selection-sort readout.
module sntt_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  sntt_in_if.sink                       in_ch,
  output sntt_pkg::ram_req_t            ram_req,
  input  logic [sntt_pkg::SLOT_W-1:0]   ram_rdata,
  output sntt_pkg::push_t               push,
  input  logic                          push_ready
);

  localparam int N = sntt_pkg::TABLE_ENTRIES;
  localparam int IW = sntt_pkg::IDX_W;
  localparam int CW = sntt_pkg::CNT_W;

  sntt_pkg::state_t state_r, state_nxt;

  sntt_pkg::slot_t req_r, req_nxt;
  logic            eos_r, eos_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   scan_r, scan_nxt;
  logic            chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]   chk_idx_r, chk_idx_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   found_idx_r, found_idx_nxt;
  logic signed [sntt_pkg::STR_W-1:0] found_str_r, found_str_nxt;
  logic [IW-1:0]   weak_idx_r, weak_idx_nxt;
  logic signed [sntt_pkg::STR_W-1:0] weak_str_r, weak_str_nxt;
  logic [CW-1:0]   rank_r, rank_nxt;
  logic [N-1:0]    done_r, done_nxt;
  logic            best_vld_r, best_vld_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  sntt_pkg::slot_t best_r, best_nxt;

  sntt_pkg::slot_t rd_slot;
  logic            in_acc;
  logic            sweeping;
  logic            issue;
  logic            sweep_done;
  logic            emit_last;

  assign rd_slot    = sntt_pkg::slot_t'(ram_rdata);
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign sweeping   = (state_r == sntt_pkg::ST_SCAN) || (state_r == sntt_pkg::ST_SORT);
  assign issue      = sweeping && (scan_r < fill_r);
  assign sweep_done = !issue && !chk_vld_r;
  assign emit_last  = (fill_r == '0) || ((rank_r + CW'(1)) == fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sntt_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_ch.key_empty) begin
            state_nxt = sntt_pkg::ST_SCAN;
          end else if (in_ch.end_of_scan) begin
            state_nxt = sntt_pkg::ST_SORT;
          end
        end
      end
      sntt_pkg::ST_SCAN: begin
        if (sweep_done) begin
          state_nxt = sntt_pkg::ST_MERGE;
        end
      end
      sntt_pkg::ST_MERGE: begin
        state_nxt = eos_r ? sntt_pkg::ST_SORT : sntt_pkg::ST_IDLE;
      end
      sntt_pkg::ST_SORT: begin
        if (sweep_done) begin
          state_nxt = sntt_pkg::ST_EMIT;
        end
      end
      sntt_pkg::ST_EMIT: begin
        if (push_ready) begin
          state_nxt = emit_last ? sntt_pkg::ST_IDLE : sntt_pkg::ST_SORT;
        end
      end
      default: state_nxt = sntt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt       = req_r;
    eos_nxt       = eos_r;
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    found_str_nxt = found_str_r;
    weak_idx_nxt  = weak_idx_r;
    weak_str_nxt  = weak_str_r;
    rank_nxt      = rank_r;
    done_nxt      = done_r;
    best_vld_nxt  = best_vld_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = weak_idx_r;
    ram_req.wdata = req_r;
    ram_req.re    = issue;
    ram_req.raddr = scan_r[IW-1:0];

    push.push              = 1'b0;
    push.item.entry_valid  = best_vld_r;
    push.item.out_key      = best_vld_r ? best_r.key : '0;
    push.item.out_strength = best_vld_r ? best_r.strength : '0;
    push.item.out_secured  = best_vld_r && best_r.secured;
    push.item.out_last     = emit_last;

    case (state_r)
      sntt_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_nxt.key      = in_ch.network_key;
          req_nxt.strength = in_ch.signal_strength;
          req_nxt.secured  = in_ch.secured;
          eos_nxt          = in_ch.end_of_scan;
          scan_nxt         = '0;
          found_nxt        = 1'b0;
          rank_nxt         = '0;
          done_nxt         = '0;
          best_vld_nxt     = 1'b0;
        end
      end
      sntt_pkg::ST_SCAN: begin
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        chk_vld_nxt = issue;
        chk_idx_nxt = scan_r[IW-1:0];
        if (chk_vld_r) begin
          if (!found_r && (rd_slot.key == req_r.key)) begin
            found_nxt     = 1'b1;
            found_idx_nxt = chk_idx_r;
            found_str_nxt = rd_slot.strength;
          end
          if ((chk_idx_r == '0) || ($signed(rd_slot.strength) < $signed(weak_str_r))) begin
            weak_idx_nxt = chk_idx_r;
            weak_str_nxt = rd_slot.strength;
          end
        end
      end
      sntt_pkg::ST_MERGE: begin
        if (found_r) begin
          ram_req.we    = $signed(req_r.strength) > $signed(found_str_r);
          ram_req.waddr = found_idx_r;
        end else if (fill_r < CW'(N)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = fill_r[IW-1:0];
          fill_nxt      = fill_r + CW'(1);
        end else begin
          ram_req.we    = $signed(req_r.strength) > $signed(weak_str_r);
          ram_req.waddr = weak_idx_r;
        end
        scan_nxt = '0;
      end
      sntt_pkg::ST_SORT: begin
        if (issue) begin
          scan_nxt = scan_r + CW'(1);
        end
        chk_vld_nxt = issue;
        chk_idx_nxt = scan_r[IW-1:0];
        if (chk_vld_r && !done_r[chk_idx_r]) begin
          if (!best_vld_r || ($signed(rd_slot.strength) > $signed(best_r.strength))) begin
            best_vld_nxt = 1'b1;
            best_idx_nxt = chk_idx_r;
            best_nxt     = rd_slot;
          end
        end
      end
      sntt_pkg::ST_EMIT: begin
        push.push = 1'b1;
        if (push_ready) begin
          if (best_vld_r) begin
            done_nxt[best_idx_r] = 1'b1;
          end
          rank_nxt     = rank_r + CW'(1);
          scan_nxt     = '0;
          best_vld_nxt = 1'b0;
          if (emit_last) begin
            fill_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready = (state_r == sntt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sntt_pkg::ST_IDLE;
      fill_r     <= '0;
      scan_r     <= '0;
      chk_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      rank_r     <= '0;
      done_r     <= '0;
      best_vld_r <= 1'b0;
      eos_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      scan_r     <= scan_nxt;
      chk_vld_r  <= chk_vld_nxt;
      found_r    <= found_nxt;
      rank_r     <= rank_nxt;
      done_r     <= done_nxt;
      best_vld_r <= best_vld_nxt;
      eos_r      <= eos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    chk_idx_r   <= chk_idx_nxt;
    found_idx_r <= found_idx_nxt;
    found_str_r <= found_str_nxt;
    weak_idx_r  <= weak_idx_nxt;
    weak_str_r  <= weak_str_nxt;
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
  end

endmodule

// ===== rtl/sntt_obuf.sv =====
// Result output register between the sequencer and the result channel.
module sntt_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  sntt_pkg::push_t  push,
  output logic             push_ready,
  sntt_out_if.source       out_ch
);

  logic              vld_r, vld_nxt;
  sntt_pkg::result_t item_r, item_nxt;

  assign push_ready = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (push.push && push_ready) begin
      vld_nxt  = 1'b1;
      item_nxt = push.item;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.entry_valid  = item_r.entry_valid;
  assign out_ch.out_key      = item_r.out_key;
  assign out_ch.out_strength = item_r.out_strength;
  assign out_ch.out_secured  = item_r.out_secured;
  assign out_ch.out_last     = item_r.out_last;

endmodule

// ===== rtl/sntt_chk.sv =====
// Port-level checker for the top-k table, bound to the top level.
module sntt_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_key_empty,
  input logic                               in_end_of_scan,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_entry_valid,
  input logic [sntt_pkg::KEY_W-1:0]         out_key,
  input logic signed [sntt_pkg::STR_W-1:0]  out_strength,
  input logic                               out_secured,
  input logic                               out_last
);

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!in_key_empty || in_end_of_scan) |=> !in_ready)
    else $error("request accepted while previous request still in progress");

  a_no_accept_mid_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready during readout");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("empty-table result not marked last");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_entry_valid, out_key, out_strength, out_secured, out_last}))
    else $error("stalled result changed");

endmodule

bind strongest_network_topk_table sntt_chk u_sntt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_key_empty    (in_ch.key_empty),
  .in_end_of_scan  (in_ch.end_of_scan),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_entry_valid (out_ch.entry_valid),
  .out_key         (out_ch.out_key),
  .out_strength    (out_ch.out_strength),
  .out_secured     (out_ch.out_secured),
  .out_last        (out_ch.out_last)
);
